// ----- rtl/sems_pkg.sv -----
package sems_pkg;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_EE_READ = 2'd1;
  localparam logic [1:0] FUNC_LIU_RD  = 2'd2;
  localparam logic [1:0] FUNC_LIU_WR  = 2'd3;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_EE   = 2'd1;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] addr;
    logic [4:0] wdata;
    logic       port;
    logic       serial_in;
  } sems_in_t;

  typedef struct packed {
    logic        chip_sel;
    logic        serial_clk;
    logic        serial_out;
    logic [1:0]  target;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
  } sems_out_t;

endpackage

// ----- rtl/serial_eeprom_and_liu_shift_master_core.sv -----
// Three-wire serial master for a 93C46-style EEPROM and a line-interface unit.
// Every input beat is one tick of the bit sequencer. A beat with func set to
// a command starts a transaction when the master is idle and is treated as a
// plain tick while busy. Each input beat yields exactly one result beat with
// the pin levels for that tick, the selected target, busy and done flags, and
// the assembled read word on the done beat.
// Input channel: in_valid / in_stall / in_data. Result channel: out_valid /
// out_stall / out_data. A beat moves when valid is high and stall is low.
// An accepted beat's result is registered in the output or skid register.
// Throughput is one beat per cycle while in_stall is low: the sequencer state
// advances from the current state and the input beat on each accepted beat.
// A two-entry result stage (output register plus skid register) lets the
// master take a new beat while a result waits; in_stall rises only once both
// entries are full and comes straight from a register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the result stage. While the receiver stalls, out_data holds its value.
module serial_eeprom_and_liu_shift_master_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sems_pkg::sems_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sems_pkg::sems_out_t out_data
);
  import sems_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_EE   = 2'd1;
  localparam logic [1:0] MODE_LRD  = 2'd2;
  localparam logic [1:0] MODE_LWR  = 2'd3;

  logic [1:0]  mode_r, mode_nxt;
  logic [4:0]  bit_idx_r, bit_idx_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] out_shift_r, out_shift_nxt;
  logic [15:0] in_shift_r, in_shift_nxt;
  logic        port_held_r, port_held_nxt;

  sems_out_t   res;
  sems_out_t   out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  logic        accept;
  logic        out_free;
  logic [4:0]  wbits, tbits, idx, idx_n;
  logic [1:0]  ph;
  logic [15:0] s;

  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    mode_nxt      = mode_r;
    bit_idx_nxt   = bit_idx_r;
    phase_nxt     = phase_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    port_held_nxt = port_held_r;
    res           = '0;
    s             = '0;
    idx           = bit_idx_r;
    idx_n         = bit_idx_r;
    ph            = (phase_r == 2'd3) ? 2'd0 : phase_r;
    wbits = (mode_r == MODE_EE) ? 5'd10 : ((mode_r == MODE_LRD) ? 5'd8 : 5'd16);
    tbits = (mode_r == MODE_EE) ? 5'd26 : 5'd16;

    if (mode_r == MODE_IDLE) begin
      if (in_data.func != FUNC_TICK) begin
        if (in_data.func == FUNC_EE_READ) begin
          // Start bits 0,1,1,0, then the address MSB first.
          s[3:0] = 4'b0110;
          for (int i = 0; i < 6; i++) begin
            s[9 - i] = in_data.addr[i];
          end
        end else begin
          s[0]   = (in_data.func == FUNC_LIU_RD);
          s[4:1] = in_data.addr[3:0];
          if (in_data.func == FUNC_LIU_WR) begin
            s[12:8] = in_data.wdata;
          end
        end
        mode_nxt      = in_data.func;
        bit_idx_nxt   = '0;
        phase_nxt     = '0;
        out_shift_nxt = s;
        in_shift_nxt  = '0;
        port_held_nxt = in_data.port;
        res.chip_sel  = 1'b1;
        res.busy_res  = 1'b1;
        res.target    = (in_data.func == FUNC_EE_READ) ? TGT_EE : {1'b1, in_data.port};
      end
    end else begin
      res.chip_sel = 1'b1;
      res.target   = (mode_r == MODE_EE) ? TGT_EE : {1'b1, port_held_r};
      if (idx < wbits) begin
        res.serial_out = out_shift_r[idx[3:0]];
        if (ph == 2'd0) begin
          phase_nxt = 2'd1;
        end else if (ph == 2'd1) begin
          res.serial_clk = 1'b1;
          phase_nxt      = 2'd2;
        end else begin
          phase_nxt = 2'd0;
          idx_n     = idx + 5'd1;
        end
      end else begin
        if (ph == 2'd0) begin
          res.serial_clk = 1'b1;
          if (mode_r == MODE_EE) begin
            in_shift_nxt = {in_shift_r[14:0], in_data.serial_in};
          end else begin
            // LIU read bits start at bit 8, so the low three index bits
            // give the bit position, LSB first.
            in_shift_nxt[{1'b0, idx[2:0]}] = in_shift_r[{1'b0, idx[2:0]}] | in_data.serial_in;
          end
          phase_nxt = 2'd1;
        end else begin
          phase_nxt = 2'd0;
          idx_n     = idx + 5'd1;
        end
      end
      bit_idx_nxt = idx_n;
      if (idx_n >= tbits) begin
        res.done_res = 1'b1;
        if (mode_r == MODE_EE) begin
          res.read_data = {in_shift_nxt[7:0], in_shift_nxt[15:8]};
        end else if (mode_r == MODE_LRD) begin
          res.read_data = {8'd0, in_shift_nxt[7:0]};
        end
        mode_nxt    = MODE_IDLE;
        bit_idx_nxt = '0;
        phase_nxt   = '0;
      end else begin
        res.busy_res = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      bit_idx_r   <= '0;
      phase_r     <= '0;
      out_shift_r <= '0;
      in_shift_r  <= '0;
      port_held_r <= 1'b0;
    end else if (accept) begin
      mode_r      <= mode_nxt;
      bit_idx_r   <= bit_idx_nxt;
      phase_r     <= phase_nxt;
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
      port_held_r <= port_held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

endmodule

// ----- rtl/sems_checker.sv -----
module sems_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sems_pkg::sems_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sems_pkg::sems_out_t out_data
);
  import sems_pkg::*;

  // The result stage is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A finishing beat shows chip select high with the clock low and no longer busy.
  a_done_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |->
      out_data.chip_sel && !out_data.serial_clk && !out_data.busy_res)
    else $error("done beat with wrong pin levels");

  // Without chip select the beat is an idle tick and every field is zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chip_sel |-> out_data == '0)
    else $error("idle beat carries nonzero fields");

  // Read data is only reported on a finishing beat.
  a_rdata_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.read_data == 16'd0)
    else $error("read data outside a done beat");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind serial_eeprom_and_liu_shift_master_core sems_checker u_sems_checker (.*);

// ----- tb/sems_pin_checker.sv -----
module sems_pin_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sems_pkg::sems_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sems_pkg::sems_out_t out_data,
  output int                  mismatch_count,
  output int                  pins_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import sems_pkg::*;

  localparam logic [1:0] MODE_IDLE = FUNC_TICK;

  // Shadow copy of the sequencer.
  logic [1:0]  seq_mode;
  logic [4:0]  seq_bit;
  logic [1:0]  seq_phase;
  logic [17:0] tx_bits;
  logic [15:0] rx_word;
  logic        port_latch;

  sems_out_t expected_pins[$];

  initial begin
    mismatch_count = 0;
    pins_outstanding = 0;
  end

  function automatic logic [1:0] selected_target();
    if (seq_mode == MODE_IDLE) begin
      return TGT_NONE;
    end
    if (seq_mode == FUNC_EE_READ) begin
      return TGT_EE;
    end
    return {1'b1, port_latch};
  endfunction

  function automatic sems_out_t step_sequencer(input sems_in_t b);
    sems_out_t   r;
    logic [17:0] s;
    int unsigned wbits;
    int unsigned tbits;
    int unsigned idx;
    logic [1:0]  ph;
    r = '0;
    if (seq_mode == MODE_IDLE) begin
      if (b.func != FUNC_TICK) begin
        s = '0;
        if (b.func == FUNC_EE_READ) begin
          // Start bit and read opcode go out first, then the address MSB first.
          s[3:0] = 4'b0110;
          for (int i = 0; i < 6; i++) begin
            s[4 + i] = b.addr[5 - i];
          end
        end else begin
          s[0] = (b.func == FUNC_LIU_RD);
          s[4:1] = b.addr[3:0];
          if (b.func == FUNC_LIU_WR) begin
            s[12:8] = b.wdata;
          end
        end
        seq_mode = b.func;
        seq_bit = '0;
        seq_phase = '0;
        tx_bits = s;
        rx_word = '0;
        port_latch = b.port;
        r.chip_sel = 1'b1;
        r.busy_res = 1'b1;
        r.target = selected_target();
      end
    end else begin
      wbits = (seq_mode == FUNC_EE_READ) ? 10 : (seq_mode == FUNC_LIU_RD) ? 8 : 16;
      tbits = (seq_mode == FUNC_EE_READ) ? 26 : 16;
      idx = seq_bit;
      ph = (seq_phase == 2'd3) ? 2'd0 : seq_phase;
      r.chip_sel = 1'b1;
      r.target = selected_target();
      if (idx < wbits) begin
        r.serial_out = tx_bits[idx];
        if (ph == 2'd0) begin
          seq_phase = 2'd1;
        end else if (ph == 2'd1) begin
          r.serial_clk = 1'b1;
          seq_phase = 2'd2;
        end else begin
          seq_phase = 2'd0;
          idx++;
        end
      end else begin
        if (ph == 2'd0) begin
          r.serial_clk = 1'b1;
          if (seq_mode == FUNC_EE_READ) begin
            rx_word = {rx_word[14:0], b.serial_in};
          end else if (idx - wbits < 16) begin
            rx_word[idx - wbits] = b.serial_in;
          end
          seq_phase = 2'd1;
        end else begin
          seq_phase = 2'd0;
          idx++;
        end
      end
      seq_bit = 5'(idx);
      if (idx >= tbits) begin
        r.done_res = 1'b1;
        if (seq_mode == FUNC_EE_READ) begin
          r.read_data = {rx_word[7:0], rx_word[15:8]};
        end else if (seq_mode == FUNC_LIU_RD) begin
          r.read_data = {8'h00, rx_word[7:0]};
        end
        seq_mode = MODE_IDLE;
        seq_bit = '0;
        seq_phase = '0;
      end else begin
        r.busy_res = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_val,
                                      input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    sems_out_t want;
    if (!rst_n) begin
      seq_mode = MODE_IDLE;
      seq_bit = '0;
      seq_phase = '0;
      tx_bits = '0;
      rx_word = '0;
      port_latch = 1'b0;
      expected_pins.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_pins.push_back(step_sequencer(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          $error("result beat with no expected result pending");
          mismatch_count++;
        end else begin
          want = expected_pins.pop_front();
          check_field("chip_sel", 16'(want.chip_sel), 16'(out_data.chip_sel));
          check_field("serial_clk", 16'(want.serial_clk), 16'(out_data.serial_clk));
          check_field("serial_out", 16'(want.serial_out), 16'(out_data.serial_out));
          check_field("target", 16'(want.target), 16'(out_data.target));
          check_field("busy_res", 16'(want.busy_res), 16'(out_data.busy_res));
          check_field("done_res", 16'(want.done_res), 16'(out_data.done_res));
          check_field("read_data", want.read_data, out_data.read_data);
        end
      end
    end
    pins_outstanding = expected_pins.size();
  end

endmodule

// ----- tb/serial_eeprom_and_liu_shift_master_core_test.sv -----
module serial_eeprom_and_liu_shift_master_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sems_pkg::*;

  localparam int RANDOM_BEATS = 1480;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 80;

  // Serial_in patterns for a transaction.
  localparam int SIN_RANDOM = 0;
  localparam int SIN_ONES   = 1;
  localparam int SIN_ZEROS  = 2;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  sems_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sems_out_t out_data;

  int mismatch_count;
  int pins_outstanding;
  int cycle_count = 0;
  int beats_sent = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_requests = 0;

  serial_eeprom_and_liu_shift_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sems_pin_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .mismatch_count   (mismatch_count),
    .pins_outstanding (pins_outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: a randomly chosen stall style that is redrawn when its random run runs out, plus
  // long hold-offs on request.
  always @(negedge clk) begin
    static int style = 0;
    static int style_left = 0;
    static int hold_left = 0;
    static int hold_grants = 0;
    static int phase_cnt = 0;
    if (hold_grants != hold_requests) begin
      hold_grants = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (style_left == 0) begin
      style = $urandom_range(0, 3);
      style_left = $urandom_range(50, 300);
    end
    style_left--;
    phase_cnt++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (style)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_stall <= (phase_cnt % 7 < 3);
        end
      endcase
    end
  end

  task automatic offer(input sems_in_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    beats_sent++;
  endtask

  function automatic sems_in_t random_beat(input logic [1:0] f);
    sems_in_t b;
    b.func = f;
    b.addr = 6'($urandom);
    b.wdata = 5'($urandom);
    b.port = 1'($urandom);
    b.serial_in = 1'($urandom);
    return b;
  endfunction

  // One command followed by exactly the ticks its transaction needs; some
  // ticks carry commands, which the busy sequencer must ignore.
  task automatic run_transaction(input logic [1:0] f, input logic [5:0] addr,
                                 input logic [4:0] wdata, input logic port,
                                 input int busy_cmd_pct, input int sin_mode);
    sems_in_t b;
    int ticks;
    b = random_beat(f);
    b.addr = addr;
    b.wdata = wdata;
    b.port = port;
    offer(b);
    ticks = (f == FUNC_EE_READ) ? 62 : (f == FUNC_LIU_RD) ? 40 : 48;
    for (int i = 0; i < ticks; i++) begin
      b = random_beat(FUNC_TICK);
      if ($urandom_range(1, 100) <= busy_cmd_pct) begin
        b.func = 2'($urandom_range(1, 3));
      end
      if (sin_mode == SIN_ONES) begin
        b.serial_in = 1'b1;
      end else if (sin_mode == SIN_ZEROS) begin
        b.serial_in = 1'b0;
      end
      offer(b);
    end
  endtask

  initial begin
    sems_in_t b;
    int txn;
    int stop_at;
    logic [1:0] f;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle ticks, with every other field at its extremes.
    b = '0;
    offer(b);
    b = '1;
    b.func = FUNC_TICK;
    offer(b);
    run_transaction(FUNC_EE_READ, 6'h3f, 5'h00, 1'b0, 0, SIN_ONES);
    run_transaction(FUNC_EE_READ, 6'h00, 5'h1f, 1'b1, 0, SIN_ZEROS);
    run_transaction(FUNC_EE_READ, 6'h2a, 5'h00, 1'b0, 60, SIN_RANDOM);
    run_transaction(FUNC_LIU_RD, 6'h3f, 5'h1f, 1'b1, 0, SIN_ONES);
    run_transaction(FUNC_LIU_RD, 6'h30, 5'h00, 1'b0, 0, SIN_ZEROS);
    run_transaction(FUNC_LIU_WR, 6'h00, 5'h1f, 1'b0, 0, SIN_RANDOM);
    run_transaction(FUNC_LIU_WR, 6'h3f, 5'h00, 1'b1, 100, SIN_RANDOM);
    b = '0;
    offer(b);

    stop_at = beats_sent + RANDOM_BEATS;
    txn = 0;
    while (beats_sent < stop_at) begin
      txn++;
      no_gaps = ($urandom_range(0, 5) == 0);
      if (txn == 4) begin
        hold_requests++;
      end
      if (txn == 12) begin
        // Let the pipeline drain completely before going on.
        in_valid <= 1'b0;
        @(negedge clk);
        while (pins_outstanding != 0) @(negedge clk);
      end
      if ($urandom_range(0, 99) < 85) begin
        f = 2'($urandom_range(1, 3));
        run_transaction(f, 6'($urandom), 5'($urandom), 1'($urandom),
                        $urandom_range(0, 40), SIN_RANDOM);
        repeat ($urandom_range(0, 2)) begin
          offer(random_beat(FUNC_TICK));
        end
      end else begin
        // Noise: arbitrary beats that may start a transaction of their own.
        repeat ($urandom_range(1, 6)) begin
          offer(random_beat(2'($urandom)));
        end
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pins_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- serial_eeprom_and_liu_shift_master_core.f -----
rtl/sems_pkg.sv
rtl/serial_eeprom_and_liu_shift_master_core.sv
rtl/sems_checker.sv
tb/sems_pin_checker.sv
tb/serial_eeprom_and_liu_shift_master_core_test.sv
